>>> rtl/mslcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG package
// Shared widths, constants and interface types of the draw unit.
// ----------------------------------------------------------------------------
package mslcg_pkg;

    localparam int RANGE_W = 31;
    localparam int STATE_W = 31;
    localparam int SEED_W  = 32;

    // Modulus 2^31-1. An all-ones state also stands for a residue of zero.
    localparam logic [STATE_W-1:0] LCG_MOD         = 31'h7FFF_FFFF;
    localparam logic [STATE_W-1:0] LCG_RESET_STATE = 31'd1622650073;

    typedef struct packed {
        logic [RANGE_W-1:0] draw_range;
        logic [STATE_W-1:0] state_value;
    } draw_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

>>> rtl/minimal_standard_lcg_draw_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG draw unit
// Lehmer generator (16807 modulo 2^31-1) returning a scaled draw and the
// raw state for each request word.
// ----------------------------------------------------------------------------
// Each request word advances the generator state once through a single
// 16807 multiply-and-fold unit in the front end, so one word is taken per
// cycle while the request queue has room and no warm-up runs. The scaled draw
// floor(draw_range * state / (2^31-1)) is formed in a two-stage back end
// (one 31x31 multiply, then a fold and compare). Each accepted request
// passes through the request queue, the product register and the output
// register before m_tvalid rises. A write of the seed register holds s_tready
// low for the three warm-up steps of the state loop that follow it; the user
// must write the seed only while the unit is idle; the unit does not check this.
module minimal_standard_lcg_draw_unit
    import mslcg_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // seed_value (signed)
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [30:0] draw_range, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata        // [30:0] draw_value, [61:31] state_value, [63:62] zero
);

    draw_req_t    q_wr_req;
    draw_req_t    q_rd_req;
    fifo_status_t q_status;
    logic         q_push;
    logic         q_pop;

    mslcg_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_range     (s_tdata[RANGE_W-1:0]),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_wr_req    (q_wr_req)
    );

    mslcg_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_req  (q_wr_req),
        .pop     (q_pop),
        .rd_req  (q_rd_req),
        .status  (q_status)
    );

    mslcg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_req   (q_rd_req),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A seed write always starts warm-up, which blocks new words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("request accepted right after a seed write");

    // The generator state is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[61:31] != '0))
        else $error("result word carries a zero state");

    // The front end never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("push into a full request queue");

    // A pop only happens on a non-empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("pop from an empty request queue");

endmodule

>>> rtl/mslcg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCG front end
// Holds the generator state, loads seeds with warm-up steps and advances the
// state once for each accepted draw request, queuing request and new state.
// ----------------------------------------------------------------------------
module mslcg_front
    import mslcg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [SEED_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [RANGE_W-1:0]  s_range,
    input  fifo_status_t        q_status,
    output logic                q_push,
    output draw_req_t           q_wr_req
);

    localparam logic [1:0] WARM_STEPS = 2'd3;
    localparam logic [14:0] LCG_MUL   = 15'd16807;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [1:0]         warm_cnt_reg;
    logic [1:0]         warm_cnt_next;
    logic [STATE_W-1:0] step_state;
    logic [STATE_W-1:0] seed_state;

    // 16807*x mod (2^31-1) by folding the high bits onto the low bits.
    function automatic logic [STATE_W-1:0] lcg_step(input logic [STATE_W-1:0] x);
        logic [45:0] prod;
        logic [31:0] sum;
        prod = 46'(x) * 46'(LCG_MUL);
        sum  = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
        return sum[30:0] + {30'd0, sum[31]};
    endfunction

    // Signed seed reduced to 1..M, with a multiple of M held as M.
    function automatic logic [STATE_W-1:0] seed_reduce(input logic [SEED_W-1:0] seed);
        logic [STATE_W-1:0] low;
        logic [STATE_W-1:0] res;
        low = seed[30:0];
        if (!seed[31]) begin
            res = (low == '0) ? LCG_MOD : low;
        end else if (low == '0) begin
            res = LCG_MOD - 31'd1;
        end else if (low == 31'd1) begin
            res = LCG_MOD;
        end else begin
            res = low - 31'd1;
        end
        return res;
    endfunction

    assign step_state = lcg_step(state_reg);
    assign seed_state = seed_reduce(cfg_wr_data);
    assign s_tready   = (warm_cnt_reg == 2'd0) && !q_status.full;
    assign q_push     = s_tvalid && s_tready;

    assign q_wr_req.draw_range  = s_range;
    assign q_wr_req.state_value = step_state;

    always_comb begin
        state_next    = state_reg;
        warm_cnt_next = warm_cnt_reg;
        if (cfg_wr_en) begin
            state_next    = seed_state;
            warm_cnt_next = WARM_STEPS;
        end else if (warm_cnt_reg != 2'd0) begin
            state_next    = step_state;
            warm_cnt_next = warm_cnt_reg - 2'd1;
        end else if (q_push) begin
            state_next = step_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= LCG_RESET_STATE;
            warm_cnt_reg <= 2'd0;
        end else begin
            state_reg    <= state_next;
            warm_cnt_reg <= warm_cnt_next;
        end
    end

endmodule

>>> rtl/mslcg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCG request queue
// Short register queue that decouples the state loop from the scaling path.
// ----------------------------------------------------------------------------
module mslcg_fifo
    import mslcg_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  draw_req_t    wr_req,
    input  logic         pop,
    output draw_req_t    rd_req,
    output fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    draw_req_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign rd_req       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/mslcg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCG range scaling
// Two-stage pipeline: range times state, then exact floor division by
// 2^31-1, feeding the registered result word.
// ----------------------------------------------------------------------------
module mslcg_back
    import mslcg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  draw_req_t    rd_req,
    input  fifo_status_t q_status,
    output logic         q_pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata
);

    logic               s1_valid_reg;
    logic [61:0]        s1_prod_reg;
    logic [STATE_W-1:0] s1_state_reg;
    logic               out_valid_reg;
    logic [RANGE_W-1:0] out_draw_reg;
    logic [STATE_W-1:0] out_state_reg;

    logic               out_ready;
    logic               s1_ready;
    logic [61:0]        prod;
    logic [31:0]        fold_sum;
    logic [1:0]         fold_carry;
    logic [RANGE_W-1:0] draw;

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_pop     = !q_status.empty && s1_ready;

    assign prod = 62'(rd_req.draw_range) * 62'(rd_req.state_value);

    // With P = a*2^31 + b, floor(P/M) = a + floor((a+b)/M), and a+b <= 2M.
    assign fold_sum = {1'b0, s1_prod_reg[61:31]} + {1'b0, s1_prod_reg[30:0]};
    always_comb begin
        if (fold_sum >= {LCG_MOD, 1'b0}) begin
            fold_carry = 2'd2;
        end else if (fold_sum >= {1'b0, LCG_MOD}) begin
            fold_carry = 2'd1;
        end else begin
            fold_carry = 2'd0;
        end
    end
    assign draw = s1_prod_reg[61:31] + {29'd0, fold_carry};

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_prod_reg  <= prod;
            s1_state_reg <= rd_req.state_value;
        end
        if (s1_valid_reg && out_ready) begin
            out_draw_reg  <= draw;
            out_state_reg <= s1_state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= q_pop;
            end
            if (out_ready) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_state_reg, out_draw_reg};

endmodule

>>> sim/minimal_standard_lcg_draw_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimal standard LCG draw unit testbench
// Sends draw requests under a series of seeds. For each accepted request
// the bench steps its own copy of the Lehmer state (16807 mod 2^31-1) and
// forms the scaled draw. Every result word is then compared with the oldest
// prediction. Both sides idle in random bursts, and the receiver stalls
// once for a long stretch.
// ----------------------------------------------------------------------------
module minimal_standard_lcg_draw_unit_tb;
    import mslcg_pkg::*;

    localparam longint MODULUS        = 64'd2147483647;
    localparam longint MULTIPLIER     = 64'd16807;
    localparam longint SCHRAGE_Q      = 64'd127773;
    localparam longint SCHRAGE_R      = 64'd2836;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_ITEMS    = 116;
    localparam int     LONG_HOLD      = 300;
    localparam int     DRAIN_CYCLES   = 12;
    localparam int     WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [RANGE_W-1:0] draw_value;
        logic [STATE_W-1:0] state_value;
    } draw_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = 32'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [63:0] m_tdata;

    logic [RANGE_W-1:0] draw_ranges[$];
    draw_result_t       predicted_draws[$];
    longint             gen_state;

    logic quiet      = 1'b0;
    logic hold_armed = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_left  = 0;
    int   send_gap   = 0;
    int   take_gap   = 0;
    int   idle_cycles = 0;
    int   requests_sent = 0;
    int   results_checked = 0;
    int   seeds_loaded = 0;
    int   mismatches = 0;

    minimal_standard_lcg_draw_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Schrage's form keeps every intermediate within 32 signed bits, so a
    // negative seed is stepped the same way as a positive one.
    function automatic longint lehmer_advance(input longint s);
        longint t;
        t = MULTIPLIER * (s % SCHRAGE_Q) - SCHRAGE_R * (s / SCHRAGE_Q);
        if (t <= 0) begin
            t = t + MODULUS;
        end
        return t;
    endfunction

    function automatic longint seed_warm_up(input logic [31:0] seed);
        longint s;
        s = longint'($signed(seed));
        repeat (3) s = lehmer_advance(s);
        return s;
    endfunction

    function automatic draw_result_t scale_draw(input logic [RANGE_W-1:0] range,
                                                input longint st);
        longint unsigned product;
        draw_result_t    res;
        product = longint'(range) * longint'(st);
        res.draw_value  = RANGE_W'(product / MODULUS);
        res.state_value = STATE_W'(st);
        return res;
    endfunction

    // Sender: each accepted word steps the predicted generator once.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                gen_state = lehmer_advance(gen_state);
                predicted_draws.push_back(scale_draw(s_tdata[RANGE_W-1:0], gen_state));
                requests_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (draw_ranges.size() > 0) begin
                    s_tdata  <= {1'b0, draw_ranges.pop_front()};
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 14);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and applies back-pressure.
    always @(posedge aclk) begin
        draw_result_t want;
        logic [RANGE_W-1:0] got_draw;
        logic [STATE_W-1:0] got_state;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_draw  = m_tdata[RANGE_W-1:0];
                got_state = m_tdata[RANGE_W+STATE_W-1:RANGE_W];
                if (predicted_draws.size() == 0) begin
                    $error("result word with no request pending: draw_value %0d state_value %0d",
                           got_draw, got_state);
                    mismatches++;
                end else begin
                    want = predicted_draws.pop_front();
                    if (got_draw !== want.draw_value) begin
                        $error("draw_value mismatch: expected %0d, got %0d",
                               want.draw_value, got_draw);
                        mismatches++;
                    end
                    if (got_state !== want.state_value) begin
                        $error("state_value mismatch: expected %0d, got %0d",
                               want.state_value, got_state);
                        mismatches++;
                    end
                    results_checked++;
                end
            end
            if (hold_armed && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    take_gap = $urandom_range(1, 14);
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results outstanding", predicted_draws.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (draw_ranges.size() != 0 || s_tvalid || predicted_draws.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        wait_drained();
        cfg_wr_data <= seed;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gen_state = seed_warm_up(seed);
        seeds_loaded++;
    endtask

    initial begin
        logic [31:0] seed;
        gen_state = seed_warm_up(32'd1);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset seed, with ranges at both ends and alternating bit patterns.
        draw_ranges.push_back(31'd0);
        draw_ranges.push_back(31'd1);
        draw_ranges.push_back(31'h7FFF_FFFF);
        draw_ranges.push_back(31'h4000_0000);
        draw_ranges.push_back(31'h2AAA_AAAA);
        draw_ranges.push_back(31'h5555_5555);
        draw_ranges.push_back(31'd1000);

        // A zero seed folds to the modulus, where the draw equals the range.
        load_seed(32'd0);
        draw_ranges.push_back(31'd0);
        draw_ranges.push_back(31'd1);
        draw_ranges.push_back(31'h7FFF_FFFF);
        draw_ranges.push_back(31'd12345);

        // The modulus itself and its negative behave as a zero seed.
        load_seed(32'h7FFF_FFFF);
        draw_ranges.push_back(31'h7FFF_FFFF);
        draw_ranges.push_back(31'd3);
        load_seed(32'h8000_0001);
        draw_ranges.push_back(31'd99);
        draw_ranges.push_back(31'h7FFF_FFFF);

        // Most negative seed and minus one.
        load_seed(32'h8000_0000);
        draw_ranges.push_back(31'h7FFF_FFFF);
        draw_ranges.push_back(31'd1000);
        load_seed(32'hFFFF_FFFF);
        draw_ranges.push_back(31'h7FFF_FFFF);
        draw_ranges.push_back(31'd10);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            seed = (p == 0) ? 32'd1 : $urandom();
            load_seed(seed);
            if (p == 1) begin
                hold_armed <= 1'b1;
            end
            if (p == RANDOM_PHASES - 1) begin
                quiet <= 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    0:       draw_ranges.push_back($urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0);
                    1, 2:    draw_ranges.push_back(RANGE_W'($urandom_range(0, 255)));
                    3:       draw_ranges.push_back(31'd1 << $urandom_range(0, RANGE_W - 1));
                    default: draw_ranges.push_back(RANGE_W'($urandom()));
                endcase
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (predicted_draws.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_draws.size());
            mismatches++;
        end
        $display("Sent %0d draw requests over %0d seed loads (zero, modulus, negative extremes).",
                 requests_sent, seeds_loaded);
        $display("Checked %0d result words, with idle bursts and one long receiver stall.",
                 results_checked);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mslcg_pkg.sv
rtl/mslcg_front.sv
rtl/mslcg_fifo.sv
rtl/mslcg_back.sv
rtl/minimal_standard_lcg_draw_unit.sv
sim/minimal_standard_lcg_draw_unit_tb.sv
